>>> design/ecs_pkg.sv
// Shared types, register indexes, pipeline sizes and arithmetic-shift helpers
// for the environmental sensor compensation block. No dependencies.
package ecs_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_TEMP_CALIB  = 3'd0;
  localparam logic [2:0] REG_PRESS_LOW   = 3'd1;
  localparam logic [2:0] REG_PRESS_HIGH  = 3'd2;
  localparam logic [2:0] REG_PRESS_NINE  = 3'd3;
  localparam logic [2:0] REG_HUM_CALIB   = 3'd4;

  // Pressure divider: 64-bit dividend magnitude, divisor magnitude up to 2^30
  localparam int DIV_QW   = 64;
  localparam int DIV_DW   = 31;
  localparam int DIV_BPS  = 2;
  localparam int DIV_NSTG = DIV_QW / DIV_BPS;

  localparam int FRONT_STAGES = 13;
  localparam int BACK_STAGES  = 5;

  // Side information that rides along with the quotient through the divider
  typedef struct packed {
    logic        neg;
    logic        dz;
    logic [15:0] ts;
    logic [16:0] hum;
  } ecs_tag_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned sh);
    logic signed [31:0] xs;
    xs = x;
    return xs >>> sh;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned sh);
    logic signed [63:0] xs;
    xs = x;
    return xs >>> sh;
  endfunction

endpackage

>>> design/ecs_div.sv
// Pipelined unsigned restoring divider for the pressure path, two quotient
// bits per stage, with a side tag carried alongside. Depends on ecs_pkg.
module ecs_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [63:0]         in_num,
  input  logic [30:0]         in_den,
  input  ecs_pkg::ecs_tag_t   in_tag,
  output logic                out_vld,
  output logic [63:0]         out_quo,
  output ecs_pkg::ecs_tag_t   out_tag
);
  import ecs_pkg::*;

  logic              vld_r [DIV_NSTG];
  logic [DIV_DW-1:0] rem_r [DIV_NSTG];
  logic [DIV_QW-1:0] qd_r  [DIV_NSTG];
  logic [DIV_DW-1:0] den_r [DIV_NSTG];
  ecs_tag_t          tag_r [DIV_NSTG];

  for (genvar s = 0; s < DIV_NSTG; s++) begin : g_stg
    logic              vld_src;
    logic [DIV_DW-1:0] rem_src;
    logic [DIV_QW-1:0] qd_src;
    logic [DIV_DW-1:0] den_src;
    ecs_tag_t          tag_src;
    logic [DIV_DW-1:0] rem_nxt;
    logic [DIV_QW-1:0] qd_nxt;
    logic [DIV_DW:0]   trial;

    if (s == 0) begin : g_first
      assign vld_src = in_vld;
      assign rem_src = '0;
      assign qd_src  = in_num;
      assign den_src = in_den;
      assign tag_src = in_tag;
    end else begin : g_next
      assign vld_src = vld_r[s-1];
      assign rem_src = rem_r[s-1];
      assign qd_src  = qd_r[s-1];
      assign den_src = den_r[s-1];
      assign tag_src = tag_r[s-1];
    end

    // per quotient bit: shift in one dividend bit, subtract when it fits
    always_comb begin
      rem_nxt = rem_src;
      qd_nxt  = qd_src;
      trial   = '0;
      for (int b = 0; b < DIV_BPS; b++) begin
        trial = {rem_nxt, qd_nxt[DIV_QW-1]};
        if (trial >= {1'b0, den_src}) begin
          rem_nxt = DIV_DW'(trial - {1'b0, den_src});
          qd_nxt  = {qd_nxt[DIV_QW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DIV_DW-1:0];
          qd_nxt  = {qd_nxt[DIV_QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        qd_r[s]  <= qd_nxt;
        den_r[s] <= den_src;
        tag_r[s] <= tag_src;
      end
    end
  end

  assign out_vld = vld_r[DIV_NSTG-1];
  assign out_quo = qd_r[DIV_NSTG-1];
  assign out_tag = tag_r[DIV_NSTG-1];

endmodule

>>> design/env_sensor_compensation.sv
// Top level of the environmental sensor compensation pipeline.
// Depends on ecs_pkg and ecs_div.
//
// Integer compensation of one raw temperature / pressure / humidity sample
// set per item. The block is a pipeline that accepts one item every cycle
// while no stall holds it (13 front stages for temperature, humidity and
// the pressure operands, 32 divider stages that each retire two quotient
// bits, 5 back stages for the pressure correction terms, and the output
// register). The user must write calibration words through the cfg_ port
// only while no item is in flight; the block itself does not enforce it.
// The whole pipeline advances together: when the output register holds an
// item that is not taken, every stage holds and in_tready drops in the same
// cycle, so in_tready follows out_tready combinationally. Pressure is Q24.8
// pascal; when the pressure divisor is zero, pressure reads 0 and out_tuser flags it.
module env_sensor_compensation (
  input  logic        clk,
  input  logic        rst_n,
  // input item: [19:0] temp_raw, [39:20] press_raw, [55:40] hum_raw
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,
  // result item: [15:0] temp_centi, [47:16] press_q24_8, [64:48] hum_q7_10
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  // result flags: [0] press_div_zero
  output logic        out_tuser,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import ecs_pkg::*;

  // ---------------------------------------------------------------- config
  logic [47:0] temp_cal_r;
  logic [63:0] press_lo_r;
  logic [63:0] press_hi_r;
  logic [15:0] press_nine_r;
  logic [63:0] hum_cal_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r   <= '0;
      press_lo_r   <= '0;
      press_hi_r   <= '0;
      press_nine_r <= '0;
      hum_cal_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEMP_CALIB: temp_cal_r   <= cfg_data[47:0];
        REG_PRESS_LOW:  press_lo_r   <= cfg_data;
        REG_PRESS_HIGH: press_hi_r   <= cfg_data;
        REG_PRESS_NINE: press_nine_r <= cfg_data[15:0];
        REG_HUM_CALIB:  hum_cal_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack calibration words
  logic [15:0]        t1;
  logic [31:0]        t2x, t3x;
  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0]        p3x, p6x, p8x, p9x;
  logic [7:0]         h1;
  logic [31:0]        h2x, h3x, h4x, h5x, h6x;

  assign t1  = temp_cal_r[15:0];
  assign t2x = {{16{temp_cal_r[31]}}, temp_cal_r[31:16]};
  assign t3x = {{16{temp_cal_r[47]}}, temp_cal_r[47:32]};
  assign p1  = press_lo_r[15:0];
  assign p2  = press_lo_r[31:16];
  assign p3  = press_lo_r[47:32];
  assign p4  = press_lo_r[63:48];
  assign p5  = press_hi_r[15:0];
  assign p6  = press_hi_r[31:16];
  assign p7  = press_hi_r[47:32];
  assign p8  = press_hi_r[63:48];
  assign p9  = press_nine_r;
  assign p3x = {{16{p3[15]}}, p3};
  assign p6x = {{16{p6[15]}}, p6};
  assign p8x = {{16{p8[15]}}, p8};
  assign p9x = {{16{p9[15]}}, p9};
  assign h1  = hum_cal_r[7:0];
  assign h2x = {{16{hum_cal_r[23]}}, hum_cal_r[23:8]};
  assign h3x = {24'd0, hum_cal_r[31:24]};
  assign h4x = {{20{hum_cal_r[43]}}, hum_cal_r[43:32]};
  assign h5x = {{20{hum_cal_r[55]}}, hum_cal_r[55:44]};
  assign h6x = {{24{hum_cal_r[63]}}, hum_cal_r[63:56]};

  // ---------------------------------------------------------- flow control
  logic en;
  logic out_valid_r;

  // advance everything unless the output item is stuck
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  logic vld_r  [FRONT_STAGES];
  logic bvld_r [BACK_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRONT_STAGES; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < FRONT_STAGES; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // -------------------------------------------------------- front stages
  logic [19:0] adc_t;
  assign adc_t = in_tdata[19:0];

  // stage 0: temperature products
  logic [31:0] ta_w, d_w, tm0_nxt, dd0_nxt;
  logic [31:0] tm0_r, dd0_r;
  assign ta_w    = {15'd0, adc_t[19:3]} - {15'd0, t1, 1'b0};
  assign d_w     = {16'd0, adc_t[19:4]} - {16'd0, t1};
  assign tm0_nxt = ta_w * t2x;
  assign dd0_nxt = d_w * d_w;

  // side carries
  logic [19:0] pr_d_r [9];
  logic [15:0] hr_d_r [5];

  // stage 1
  logic [31:0] ta1_r, tb1_r;
  // stage 2
  logic [31:0] fine2_r;
  // stage 3
  logic [31:0]        tv_w;
  logic [15:0]        ts_nxt;
  logic [15:0]        ts_d_r [9];
  logic signed [32:0] v13_r;
  logic [31:0]        hx3_r;

  assign tv_w = asr32((fine2_r << 2) + fine2_r + 32'd128, 8);

  always_comb begin
    if ($signed(tv_w) > 32'sd32767) begin
      ts_nxt = 16'h7FFF;
    end else if ($signed(tv_w) < -32'sd32768) begin
      ts_nxt = 16'h8000;
    end else begin
      ts_nxt = tv_w[15:0];
    end
  end

  // stage 4: squares and coefficient products
  logic signed [65:0] sqf_w;
  logic [63:0]        sq4_r;
  logic signed [48:0] m54_r, m24_r;
  logic [31:0]        hm5_4_r, hm6_4_r, hm3_4_r;
  assign sqf_w = v13_r * v13_r;

  // stage 5
  logic signed [48:0] sq6l5_r, sq3l5_r, m25_r;
  logic [31:0]        sq6h5_r, sq3h5_r;
  logic [63:0]        c5_r;
  logic [31:0]        ha_d_r [3];
  logic [31:0]        hb05_r;

  // stage 6
  logic [63:0] v2_d_r [3];
  logic [63:0] v1b6_r;
  logic [31:0] hb16_r;

  // stage 7
  logic [63:0] va7_r;
  logic [31:0] hb7_r;

  // stage 8
  logic [47:0] mlo8_r;
  logic [31:0] mhi8_r;
  logic [31:0] hx_d_r [4];

  // stage 9: divisor and numerator
  logic [63:0] prod_w, pn_w;
  logic [30:0] den_d_r [3];
  logic [63:0] nm9_r;
  logic [31:0] ha29_r;
  assign prod_w = {mhi8_r, 32'd0} + {16'd0, mlo8_r};
  assign pn_w   = 64'd1048576 - {44'd0, pr_d_r[8]};

  // stage 10
  logic [43:0] n3l10_r;
  logic [31:0] n3h10_r;
  logic [31:0] haa10_r;

  // stage 11
  logic [63:0] num11_r;
  logic [31:0] ht11_r;

  // stage 12: magnitudes, sign and final humidity
  logic [63:0] ma12_r;
  logic [30:0] mb12_r;
  ecs_tag_t    tag12_r;
  logic [31:0] hxf_w;
  logic [16:0] hum_nxt;
  ecs_tag_t    tag12_nxt;

  assign hxf_w = hx_d_r[3] - asr32(ht11_r, 4);

  always_comb begin
    if (hxf_w[31]) begin
      hum_nxt = '0;
    end else if (hxf_w > 32'd419430400) begin
      hum_nxt = 17'd102400;
    end else begin
      hum_nxt = hxf_w[28:12];
    end
    tag12_nxt.neg = num11_r[63] ^ den_d_r[2][30];
    tag12_nxt.dz  = (den_d_r[2] == '0);
    tag12_nxt.ts  = ts_d_r[8];
    tag12_nxt.hum = hum_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 0
      tm0_r     <= tm0_nxt;
      dd0_r     <= dd0_nxt;
      pr_d_r[0] <= in_tdata[39:20];
      hr_d_r[0] <= in_tdata[55:40];
      for (int i = 1; i < 9; i++) pr_d_r[i] <= pr_d_r[i-1];
      for (int i = 1; i < 5; i++) hr_d_r[i] <= hr_d_r[i-1];
      // stage 1
      ta1_r <= asr32(tm0_r, 11);
      tb1_r <= asr32(dd0_r, 12) * t3x;
      // stage 2: fine temperature
      fine2_r <= ta1_r + asr32(tb1_r, 14);
      // stage 3
      ts_d_r[0] <= ts_nxt;
      for (int i = 1; i < 9; i++) ts_d_r[i] <= ts_d_r[i-1];
      v13_r <= $signed({fine2_r[31], fine2_r}) - 33'sd128000;
      hx3_r <= fine2_r - 32'd76800;
      // stage 4
      sq4_r   <= sqf_w[63:0];
      m54_r   <= v13_r * p5;
      m24_r   <= v13_r * p2;
      hm5_4_r <= h5x * hx3_r;
      hm6_4_r <= hx3_r * h6x;
      hm3_4_r <= hx3_r * h3x;
      // stage 5: split 64 x 16 products into halves
      sq6l5_r   <= $signed({1'b0, sq4_r[31:0]}) * p6;
      sq6h5_r   <= sq4_r[63:32] * p6x;
      sq3l5_r   <= $signed({1'b0, sq4_r[31:0]}) * p3;
      sq3h5_r   <= sq4_r[63:32] * p3x;
      c5_r      <= (64'(m54_r) << 17) + (64'(p4) << 35);
      m25_r     <= m24_r;
      ha_d_r[0] <= asr32({2'd0, hr_d_r[4], 14'd0} - {h4x[11:0], 20'd0}
                         - hm5_4_r + 32'd16384, 15);
      ha_d_r[1] <= ha_d_r[0];
      ha_d_r[2] <= ha_d_r[1];
      hb05_r    <= asr32(hm6_4_r, 10) * (asr32(hm3_4_r, 11) + 32'd32768);
      // stage 6
      v2_d_r[0] <= {sq6h5_r, 32'd0} + 64'(sq6l5_r) + c5_r;
      v2_d_r[1] <= v2_d_r[0];
      v2_d_r[2] <= v2_d_r[1];
      v1b6_r    <= asr64({sq3h5_r, 32'd0} + 64'(sq3l5_r), 8) + (64'(m25_r) << 12);
      hb16_r    <= (asr32(hb05_r, 10) + 32'd2097152) * h2x;
      // stage 7
      va7_r <= 64'h0000_8000_0000_0000 + v1b6_r;
      hb7_r <= asr32(hb16_r + 32'd8192, 14);
      // stage 8
      mlo8_r    <= va7_r[31:0] * p1;
      mhi8_r    <= va7_r[63:32] * {16'd0, p1};
      hx_d_r[0] <= ha_d_r[2] * hb7_r;
      for (int i = 1; i < 4; i++) hx_d_r[i] <= hx_d_r[i-1];
      // stage 9
      den_d_r[0] <= prod_w[63:33];
      den_d_r[1] <= den_d_r[0];
      den_d_r[2] <= den_d_r[1];
      nm9_r      <= (pn_w << 31) - v2_d_r[2];
      ha29_r     <= asr32(hx_d_r[0], 15);
      // stage 10
      n3l10_r <= nm9_r[31:0] * 44'd3125;
      n3h10_r <= nm9_r[63:32] * 32'd3125;
      haa10_r <= ha29_r * ha29_r;
      // stage 11
      num11_r <= {n3h10_r, 32'd0} + {20'd0, n3l10_r};
      ht11_r  <= asr32(haa10_r, 7) * {24'd0, h1};
      // stage 12
      ma12_r  <= num11_r[63] ? (64'd0 - num11_r) : num11_r;
      mb12_r  <= den_d_r[2][30] ? (31'd0 - den_d_r[2]) : den_d_r[2];
      tag12_r <= tag12_nxt;
    end
  end

  // --------------------------------------------------------------- divider
  logic        div_vld;
  logic [63:0] div_quo;
  ecs_tag_t    div_tag;

  ecs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld_r[FRONT_STAGES-1]),
    .in_num  (ma12_r),
    .in_den  (mb12_r),
    .in_tag  (tag12_r),
    .out_vld (div_vld),
    .out_quo (div_quo),
    .out_tag (div_tag)
  );

  // --------------------------------------------------------- back stages
  logic [63:0]        pb_r [BACK_STAGES];
  ecs_tag_t           tg_r [BACK_STAGES];
  logic [63:0]        v2q_w;
  logic [63:0]        ll_r;
  logic [31:0]        lh_r, p8h_r;
  logic signed [48:0] p8l_r;
  logic [63:0]        sq2_r, pp8_r;
  logic signed [48:0] s9l_r;
  logic [31:0]        s9h_r;
  logic [63:0]        v2b_r, v1c_r, v2b5_r;
  logic [63:0]        pr_w;
  logic [71:0]        out_tdata_r;
  logic               out_tuser_r;

  assign v2q_w = asr64(pb_r[0], 13);
  assign pr_w  = asr64(pb_r[4] + v1c_r + v2b5_r, 8) + (64'(p7) << 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BACK_STAGES; i++) bvld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      bvld_r[0] <= div_vld;
      for (int i = 1; i < BACK_STAGES; i++) bvld_r[i] <= bvld_r[i-1];
      out_valid_r <= bvld_r[BACK_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // restore the quotient sign
      pb_r[0] <= div_tag.neg ? (64'd0 - div_quo) : div_quo;
      tg_r[0] <= div_tag;
      for (int i = 1; i < BACK_STAGES; i++) begin
        pb_r[i] <= pb_r[i-1];
        tg_r[i] <= tg_r[i-1];
      end
      // square of p >> 13, and p * P8, as 32-bit partial products
      ll_r  <= v2q_w[31:0] * v2q_w[31:0];
      lh_r  <= v2q_w[31:0] * v2q_w[63:32];
      p8l_r <= $signed({1'b0, pb_r[0][31:0]}) * p8;
      p8h_r <= pb_r[0][63:32] * p8x;
      // combine halves
      sq2_r <= ll_r + {lh_r[30:0], 1'b0, 32'd0};
      pp8_r <= {p8h_r, 32'd0} + 64'(p8l_r);
      // times P9
      s9l_r <= $signed({1'b0, sq2_r[31:0]}) * p9;
      s9h_r <= sq2_r[63:32] * p9x;
      v2b_r <= asr64(pp8_r, 19);
      // correction terms
      v1c_r  <= asr64({s9h_r, 32'd0} + 64'(s9l_r), 25);
      v2b5_r <= v2b_r;
      // output register
      out_tdata_r <= {7'd0, tg_r[4].hum,
                      (tg_r[4].dz ? 32'd0 : pr_w[31:0]), tg_r[4].ts};
      out_tuser_r <= tg_r[4].dz;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ------------------------------------------------------------ assertions
  a_dz_forces_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[47:16] == 32'd0)
    else $error("pressure not zero on divisor fault");

  a_hum_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[64:48] <= 17'd102400)
    else $error("humidity above clamp");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a held output item");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted item missing from first stage");

endmodule
